// File: rtl/stm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the stepper trapezoid motion unit.
// No dependencies; compiled first.
package stm_pkg;

  // Position register width (16 to 32); the position port is always 32 bits.
  localparam int POS_W = 32;
  // Driver variant selects the eighth-step microstep pin code.
  localparam int DRIVER_VARIANT = 1;

  localparam int CFG_W  = 16;              // widest configuration register
  localparam int DIV_W  = 16;              // ramp divide width
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int TICK_W = 32;

  localparam logic [2:0] MS_HALF   = 3'd1;
  localparam logic [2:0] MS_EIGHTH = (DRIVER_VARIANT != 0) ? 3'd7 : 3'd3;

  // Command codes
  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_ABS   = 3'd1,
    CMD_REL   = 3'd2,
    CMD_HOME  = 3'd3,
    CMD_LIMIT = 3'd4
  } cmd_t;

  // Motion mode codes, shown on motion_state
  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_HOMING  = 2'd1,
    MODE_FWD     = 2'd2,
    MODE_BWD     = 2'd3
  } mode_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ACCEL_DIST   = 3'd0,
    REG_ACCEL_PERIOD = 3'd1,
    REG_CRUISE       = 3'd2,
    REG_HOME_PERIOD  = 3'd3,
    REG_DRV_ENABLE   = 3'd4,
    REG_DRV_AWAKE    = 3'd5
  } cfg_idx_t;

  // One result transaction
  typedef struct packed {
    logic               step_pulse;
    logic               direction;
    logic signed [31:0] position;
    logic [1:0]         motion_state;
    logic [2:0]         microstep_select;
    logic               reset_pulse;
    logic               fault;
    logic               enable_n;
    logic               sleep_n;
  } stm_result_t;

endpackage

// File: rtl/stm_in_if.sv
`timescale 1ns / 1ps
// Input channel: valid/ready handshake carrying one command transaction.
// Depends on nothing.
interface stm_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] target;
  logic               fault_in;

  modport source (output valid, command, target, fault_in, input ready);
  modport sink   (input valid, command, target, fault_in, output ready);
endinterface

// File: rtl/stm_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one result transaction.
// Depends on nothing.
interface stm_out_if;
  logic               valid;
  logic               ready;
  logic               step_pulse;
  logic               direction;
  logic signed [31:0] position;
  logic [1:0]         motion_state;
  logic [2:0]         microstep_select;
  logic               reset_pulse;
  logic               fault;
  logic               enable_n;
  logic               sleep_n;

  modport source (output valid, step_pulse, direction, position, motion_state,
                  microstep_select, reset_pulse, fault, enable_n, sleep_n,
                  input ready);
  modport sink   (input valid, step_pulse, direction, position, motion_state,
                  microstep_select, reset_pulse, fault, enable_n, sleep_n,
                  output ready);
endinterface

// File: rtl/stepper_trapezoid_motion_unit.sv
`timescale 1ns / 1ps
// Stepper step/direction generator with trapezoidal ramp, top level.
// Depends on stm_pkg, stm_in_if and stm_out_if.

// Each command transaction produces exactly one result transaction. The
// block takes one transaction at a time. A tick inside the ramp zone of a
// move passes through acceptance, a state for the distance, the restoring
// divider that forms distance / cruise_period, and a state to update state.
// Every other command skips the divider (accept, distance check, update).
// A finished result sits in an output register, so the next command is
// taken while it waits; only a second finished result stalls on it.
// Configuration writes take effect at once and belong in idle periods.
module stepper_trapezoid_motion_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  stm_in_if.sink                    in_if,
  stm_out_if.source                 out_if,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [stm_pkg::CFG_W-1:0] cfg_wdata
);
  import stm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIST  = 4'b0010,
    S_DIV   = 4'b0100,
    S_APPLY = 4'b1000
  } seq_state_t;

  // Configuration registers
  logic [15:0] accel_dist_r, accel_period_r, cruise_r, home_period_r;
  logic        drv_enable_r, drv_awake_r;

  // Sequencer and captured transaction
  seq_state_t         state_r, state_nxt;
  logic [2:0]         cmd_r;
  logic [POS_W-1:0]   tgt_r;
  logic               fault_r;

  // Divider
  logic [DIV_W-1:0]   quo_r, quo_nxt, rem_r, rem_nxt;
  logic [DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               ramp_r, ramp_nxt;

  // Motion state
  mode_t              mode_r, mode_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt, dest_r, dest_nxt, start_r, start_nxt;
  logic [TICK_W-1:0]  tc_r, tc_nxt;
  logic [2:0]         pins_r, pins_nxt;
  logic               dir_r, dir_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  stm_result_t        res_r, res_nxt;

  logic               moving, fwd, in_fire, out_free;
  logic [POS_W-1:0]   to_end, from_start, near_dist, new_dest;
  logic [DIV_W:0]     div_shift, div_diff;
  logic [15:0]        period;
  logic [TICK_W-1:0]  tc_inc;
  logic               step, rst_pulse;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE);

  assign fwd    = (mode_r == MODE_FWD);
  assign moving = (mode_r == MODE_FWD) || (mode_r == MODE_BWD);

  // Distance to the end and from the start, smaller of the two
  always_comb begin
    if (fwd) begin
      to_end     = dest_r - pos_r;
      from_start = pos_r - start_r;
    end else begin
      to_end     = pos_r - dest_r;
      from_start = start_r - pos_r;
    end
    near_dist = (to_end < from_start) ? to_end : from_start;
  end

  // Subtractor: one restoring divide step
  assign div_shift = {rem_r, quo_r[DIV_W-1]};
  assign div_diff  = div_shift - {1'b0, cruise_r};

  // Step period for this tick; a quotient at or above accel_period clamps to zero
  assign period = !ramp_r ? cruise_r :
                  (accel_period_r > quo_r) ? (accel_period_r - quo_r) : 16'd0;
  assign tc_inc   = tc_r + TICK_W'(1);
  assign new_dest = dest_r + tgt_r;

  // Sequencer and state update
  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    ramp_nxt      = ramp_r;
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    dest_nxt      = dest_r;
    start_nxt     = start_r;
    tc_nxt        = tc_r;
    pins_nxt      = pins_r;
    dir_nxt       = dir_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    res_nxt       = res_r;
    step          = 1'b0;
    rst_pulse     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_DIST;
      end
      S_DIST: begin
        ramp_nxt = 1'b0;
        state_nxt = S_APPLY;
        if (cmd_r == CMD_TICK && moving && pos_r != dest_r &&
            near_dist < POS_W'(accel_dist_r)) begin
          ramp_nxt  = 1'b1;
          quo_nxt   = near_dist[DIV_W-1:0];
          rem_nxt   = '0;
          cnt_nxt   = DCNT_W'(DIV_W);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_diff[DIV_W]) begin
          rem_nxt = div_diff[DIV_W-1:0];
          quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = div_shift[DIV_W-1:0];
          quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          case (cmd_t'(cmd_r))
            CMD_TICK: begin
              if (mode_r == MODE_HOMING) begin
                tc_nxt = tc_inc;
                if (tc_inc >= TICK_W'(home_period_r)) begin
                  tc_nxt  = '0;
                  dir_nxt = 1'b0;
                  step    = 1'b1;
                end
              end else if (moving) begin
                if (pos_r == dest_r) begin
                  mode_nxt = MODE_STOPPED;
                end else begin
                  tc_nxt = tc_inc;
                  if (tc_inc >= TICK_W'(period)) begin
                    tc_nxt  = '0;
                    dir_nxt = fwd;
                    pos_nxt = fwd ? pos_r + POS_W'(1) : pos_r - POS_W'(1);
                    step    = 1'b1;
                  end
                end
              end
            end
            CMD_ABS: begin
              start_nxt = pos_r;
              dest_nxt  = tgt_r;
              mode_nxt  = ($signed(tgt_r) < $signed(pos_r)) ? MODE_BWD : MODE_FWD;
            end
            CMD_REL: begin
              start_nxt = pos_r;
              dest_nxt  = new_dest;
              mode_nxt  = ($signed(new_dest) < $signed(pos_r)) ? MODE_BWD : MODE_FWD;
            end
            CMD_HOME: begin
              pins_nxt = MS_EIGHTH;
              mode_nxt = MODE_HOMING;
            end
            CMD_LIMIT: begin
              mode_nxt  = MODE_STOPPED;
              pos_nxt   = '0;
              pins_nxt  = MS_HALF;
              rst_pulse = 1'b1;
            end
            default: begin
            end
          endcase
          res_nxt.step_pulse       = step;
          res_nxt.direction        = dir_nxt;
          res_nxt.position         = 32'(signed'(pos_nxt));
          res_nxt.motion_state     = mode_nxt;
          res_nxt.microstep_select = pins_nxt;
          res_nxt.reset_pulse      = rst_pulse;
          res_nxt.fault            = fault_r;
          res_nxt.enable_n         = !drv_enable_r;
          res_nxt.sleep_n          = drv_awake_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and motion state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_HOMING;
      pos_r       <= '0;
      dest_r      <= '0;
      start_r     <= '0;
      tc_r        <= '0;
      pins_r      <= MS_EIGHTH;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      dest_r      <= dest_nxt;
      start_r     <= start_nxt;
      tc_r        <= tc_nxt;
      pins_r      <= pins_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: captured transaction, divider, result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_if.command;
      tgt_r   <= in_if.target[POS_W-1:0];
      fault_r <= in_if.fault_in;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    ramp_r <= ramp_nxt;
    res_r  <= res_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_dist_r   <= 16'd100;
      accel_period_r <= 16'd50;
      cruise_r       <= 16'd5;
      home_period_r  <= 16'd10;
      drv_enable_r   <= 1'b1;
      drv_awake_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_ACCEL_DIST:   accel_dist_r   <= cfg_wdata;
        REG_ACCEL_PERIOD: accel_period_r <= cfg_wdata;
        REG_CRUISE:       cruise_r       <= cfg_wdata;
        REG_HOME_PERIOD:  home_period_r  <= cfg_wdata;
        REG_DRV_ENABLE:   drv_enable_r   <= cfg_wdata[0];
        REG_DRV_AWAKE:    drv_awake_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Result channel
  assign out_if.valid            = out_valid_r;
  assign out_if.step_pulse       = res_r.step_pulse;
  assign out_if.direction        = res_r.direction;
  assign out_if.position         = res_r.position;
  assign out_if.motion_state     = res_r.motion_state;
  assign out_if.microstep_select = res_r.microstep_select;
  assign out_if.reset_pulse      = res_r.reset_pulse;
  assign out_if.fault            = res_r.fault;
  assign out_if.enable_n         = res_r.enable_n;
  assign out_if.sleep_n          = res_r.sleep_n;

endmodule

// File: rtl/stm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the stepper trapezoid motion unit, bound to the top.
// Depends on stm_pkg and stepper_trapezoid_motion_unit.
module stm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        step_pulse,
  input logic        direction,
  input logic [31:0] position,
  input logic [1:0]  motion_state,
  input logic        reset_pulse
);
  import stm_pkg::*;

  // A stalled result holds its position, step pulse and motion state
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(position) &&
                                $stable(step_pulse) && $stable(motion_state))
    else $error("result changed while stalled");

  // One transaction at a time: ready drops after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a transaction while busy");

  // Limit hit stops the motor at position zero, without a step
  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && reset_pulse |-> position == 32'd0 &&
                                 motion_state == MODE_STOPPED && !step_pulse)
    else $error("limit result inconsistent");

  // A step drives direction high only when moving forward
  a_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && step_pulse |-> direction == (motion_state == MODE_FWD))
    else $error("step direction does not match mode");

endmodule

bind stepper_trapezoid_motion_unit stm_checker u_stm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .step_pulse   (out_if.step_pulse),
  .direction    (out_if.direction),
  .position     (out_if.position),
  .motion_state (out_if.motion_state),
  .reset_pulse  (out_if.reset_pulse)
);
